[design/rmq_pkg.sv]
// Package for the rotation matrix to quaternion block.
// Branch codes and output field constants; no dependencies.
`timescale 1ns / 1ps
package rmq_pkg;

  // Shepperd branch that produced a result
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // width of one matrix element and of one quaternion component
  localparam int ELEM_W = 16;
  // quotient bits kept by the dividers; anything larger saturates
  localparam int QUO_W = 17;
  // saturation limits of a component
  localparam logic [QUO_W-1:0] POS_LIM = 17'd32767;
  localparam logic [QUO_W-1:0] NEG_LIM = 17'd32768;

endpackage

[design/rmq_if.sv]
// Valid/ready channels of the rotation matrix to quaternion block.
// Depends on rmq_pkg for the element width.
`timescale 1ns / 1ps
interface rmq_in_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::ELEM_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

interface rmq_out_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::ELEM_W-1:0] quat_x, quat_y, quat_z, quat_w;
  logic [1:0] branch_taken;
  logic       degenerate;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
                  output ready);
endinterface

[design/rotation_matrix_to_quaternion.sv]
// Top level of the rotation matrix to quaternion block (Shepperd's method).
// Depends on rmq_pkg, rmq_if, rmq_front, rmq_sqrt and rmq_div.
//
// Takes one 3x3 matrix per beat and returns the unit quaternion, the branch
// taken and a degenerate flag, one beat out per beat in. The pipeline is
// fully registered and accepts a new matrix every cycle while the output is
// not stalled. Its depth is set by the front end, the bit-per-stage square
// root of the norm and the 17 quotient stages of the normalizing dividers.
// Each stage holds its beat when the next one is full, so a stall at the
// output fills bubbles upstream before input ready drops.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst,
  rmq_in_if.sink     in_ch,
  rmq_out_if.source  out_ch
);

  localparam int MAG_W  = (FRAC_BITS >= 17) ? FRAC_BITS + 1 : 18;
  localparam int RW     = MAG_W + 1;
  localparam int SIDE_W = 4 + 4 * MAG_W + 2 + 1;

  // front end to square root
  logic                  f_valid, f_ready, f_tbad;
  logic [3:0]            f_neg;
  logic [3:0][MAG_W-1:0] f_mag;
  rmq_pkg::branch_t      f_br;
  logic [2*RW-1:0]       f_n2;

  // square root to dividers
  logic                  s_valid, s_ready;
  logic [RW-1:0]         s_norm;
  logic [SIDE_W-1:0]     s_side;
  logic [3:0]            s_neg;
  logic [3:0][MAG_W-1:0] s_mag;
  logic [1:0]            s_brb;
  logic                  s_tbad;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .MAG_W(MAG_W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_neg   (f_neg),
    .out_mag   (f_mag),
    .out_br    (f_br),
    .out_tbad  (f_tbad),
    .out_n2    (f_n2)
  );

  rmq_sqrt #(.ROOT_W(RW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_rad    (f_n2),
    .in_side   ({f_neg, f_mag, f_br, f_tbad}),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_norm),
    .out_side  (s_side)
  );

  assign {s_neg, s_mag, s_brb, s_tbad} = s_side;

  rmq_div #(.FRAC_BITS(FRAC_BITS), .MAG_W(MAG_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .in_ready (s_ready),
    .in_norm  (s_norm),
    .in_neg   (s_neg),
    .in_mag   (s_mag),
    .in_br    (rmq_pkg::branch_t'(s_brb)),
    .in_tbad  (s_tbad),
    .out_ch   (out_ch)
  );

  // a degenerate result carries an all-zero quaternion
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.degenerate |->
      out_ch.quat_x == 0 && out_ch.quat_y == 0 && out_ch.quat_z == 0 && out_ch.quat_w == 0)
    else $error("degenerate result with nonzero quaternion");

  // trace branch: scalar part comes from the positive radicand
  a_trace_w: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.degenerate && out_ch.branch_taken == rmq_pkg::BR_TRACE |->
      out_ch.quat_w >= 0)
    else $error("trace branch produced negative scalar part");

  // x branch: x component comes from the positive radicand
  a_xbr_x: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.degenerate && out_ch.branch_taken == rmq_pkg::BR_X |->
      out_ch.quat_x >= 0)
    else $error("x branch produced negative x component");

endmodule

[design/rmq_front.sv]
// Front end: branch select, radicand, component vector, squares and norm sum.
// Three register stages. Depends on rmq_pkg and rmq_in_if.
`timescale 1ns / 1ps
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int MAG_W     = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  rmq_in_if.sink                   in_ch,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_neg,
  output logic [3:0][MAG_W-1:0]    out_mag,
  output rmq_pkg::branch_t         out_br,
  output logic                     out_tbad,
  output logic [2*MAG_W+1:0]       out_n2
);

  localparam int TW  = MAG_W + 1;
  localparam int N2W = 2 * MAG_W + 2;
  localparam logic signed [TW-1:0] ONE = TW'(64'sd1 << FRAC_BITS);

  logic en1, en2, en3;
  logic vld1, vld2, vld3;

  // stage 1 registers
  logic signed [TW-1:0] v1 [4];
  logic signed [TW-1:0] t1;
  rmq_pkg::branch_t     br1;
  // stage 2 registers
  logic [3:0]             neg2;
  logic [3:0][MAG_W-1:0]  mag2;
  logic [2*MAG_W-1:0]     sq2 [4];
  rmq_pkg::branch_t       br2;
  logic                   tbad2;
  // stage 3 registers
  logic [3:0]             neg3;
  logic [3:0][MAG_W-1:0]  mag3;
  logic [N2W-1:0]         n23;
  rmq_pkg::branch_t       br3;
  logic                   tbad3;

  assign en3 = !vld3 || out_ready;
  assign en2 = !vld2 || en3;
  assign en1 = !vld1 || en2;
  assign in_ch.ready = en1;

  // branch select and vector
  logic signed [TW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, trace;
  logic signed [TW-1:0] v_next [4];
  logic signed [TW-1:0] t_next;
  rmq_pkg::branch_t     br_next;

  always_comb begin
    a00 = TW'(in_ch.r00); a01 = TW'(in_ch.r01); a02 = TW'(in_ch.r02);
    a10 = TW'(in_ch.r10); a11 = TW'(in_ch.r11); a12 = TW'(in_ch.r12);
    a20 = TW'(in_ch.r20); a21 = TW'(in_ch.r21); a22 = TW'(in_ch.r22);
    trace = a00 + a11 + a22;
    if (trace > 0) begin
      br_next = rmq_pkg::BR_TRACE;
      t_next = ONE + trace;
      v_next[0] = a21 - a12; v_next[1] = a02 - a20; v_next[2] = a10 - a01;
      v_next[3] = t_next;
    end else if (a00 > a11 && a00 > a22) begin
      br_next = rmq_pkg::BR_X;
      t_next = ONE + a00 - a11 - a22;
      v_next[0] = t_next; v_next[1] = a01 + a10; v_next[2] = a02 + a20;
      v_next[3] = a21 - a12;
    end else if (a11 > a22) begin
      br_next = rmq_pkg::BR_Y;
      t_next = ONE + a11 - a00 - a22;
      v_next[0] = a01 + a10; v_next[1] = t_next; v_next[2] = a12 + a21;
      v_next[3] = a02 - a20;
    end else begin
      br_next = rmq_pkg::BR_Z;
      t_next = ONE + a22 - a00 - a11;
      v_next[0] = a02 + a20; v_next[1] = a12 + a21; v_next[2] = t_next;
      v_next[3] = a10 - a01;
    end
  end

  // magnitudes of stage 1 vector
  logic [3:0]            neg_next;
  logic [3:0][MAG_W-1:0] mag_next;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_next[i] = v1[i][TW-1];
      mag_next[i] = neg_next[i] ? MAG_W'(-v1[i]) : MAG_W'(v1[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (en1) vld1 <= in_ch.valid;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    if (en1) begin
      v1  <= v_next;
      t1  <= t_next;
      br1 <= br_next;
    end
    if (en2) begin
      neg2  <= neg_next;
      mag2  <= mag_next;
      for (int i = 0; i < 4; i++) sq2[i] <= mag_next[i] * mag_next[i];
      br2   <= br1;
      tbad2 <= (t1 <= 0);
    end
    if (en3) begin
      neg3  <= neg2;
      mag3  <= mag2;
      n23   <= N2W'(sq2[0]) + N2W'(sq2[1]) + N2W'(sq2[2]) + N2W'(sq2[3]);
      br3   <= br2;
      tbad3 <= tbad2;
    end
  end

  assign out_valid = vld3;
  assign out_neg   = neg3;
  assign out_mag   = mag3;
  assign out_br    = br3;
  assign out_tbad  = tbad3;
  assign out_n2    = n23;

endmodule

[design/rmq_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with side data
// carried alongside. No package dependencies.
`timescale 1ns / 1ps
module rmq_sqrt #(
  parameter int ROOT_W = 19,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RADW = 2 * ROOT_W;
  localparam int REMW = ROOT_W + 2;

  logic [ROOT_W:0]     en;
  logic [ROOT_W-1:0]   vld;
  logic [REMW-1:0]     rem  [ROOT_W];
  logic [ROOT_W-1:0]   root [ROOT_W];
  logic [RADW-1:0]     rest [ROOT_W];
  logic [SIDE_W-1:0]   side [ROOT_W];

  assign en[ROOT_W] = out_ready;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_src;
    logic [REMW-1:0]   rem_src, rem_sh, trial;
    logic [ROOT_W-1:0] root_src;
    logic [RADW-1:0]   rest_src;
    logic [SIDE_W-1:0] side_src;

    if (k == 0) begin : g_first
      assign vld_src  = in_valid;
      assign rem_src  = '0;
      assign root_src = '0;
      assign rest_src = in_rad;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld[k-1];
      assign rem_src  = rem[k-1];
      assign root_src = root[k-1];
      assign rest_src = rest[k-1];
      assign side_src = side[k-1];
    end

    assign en[k] = !vld[k] || en[k+1];

    // bring down two radicand bits and try root*4+1
    assign rem_sh = {rem_src[REMW-3:0], rest_src[RADW-1 -: 2]};
    assign trial  = {root_src, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (rem_sh >= trial) begin
          rem[k]  <= rem_sh - trial;
          root[k] <= {root_src[ROOT_W-2:0], 1'b1};
        end else begin
          rem[k]  <= rem_sh;
          root[k] <= {root_src[ROOT_W-2:0], 1'b0};
        end
        rest[k] <= {rest_src[RADW-3:0], 2'b00};
        side[k] <= side_src;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule

[design/rmq_div.sv]
// Normalizing dividers: rounded dividend prep, four restoring lanes with one
// quotient bit per stage, then saturation into the output register. Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int MAG_W     = 18
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MAG_W:0]          in_norm,
  input  logic [3:0]              in_neg,
  input  logic [3:0][MAG_W-1:0]   in_mag,
  input  rmq_pkg::branch_t        in_br,
  input  logic                    in_tbad,
  rmq_out_if.source               out_ch
);

  localparam int RW  = MAG_W + 1;
  localparam int QW  = rmq_pkg::QUO_W;
  localparam int DW  = MAG_W + FRAC_BITS + 1;
  localparam int CW  = (DW > RW + QW + 1) ? DW : RW + QW + 1;
  localparam int NS  = QW + 2;   // prep, QW bit stages, output
  localparam int OW  = rmq_pkg::ELEM_W;

  logic [NS:0]   en;
  logic [NS-1:0] vld;

  // per stage payload
  logic [CW-1:0]    rem  [NS-1][4];
  logic [QW-1:0]    quo  [NS-1][4];
  logic [3:0]       sat  [NS-1];
  logic [3:0]       neg  [NS-1];
  logic [CW-1:0]    dvs  [NS-1];
  rmq_pkg::branch_t br   [NS-1];
  logic             dgn  [NS-1];

  // output register
  logic signed [OW-1:0] q_out [4];
  rmq_pkg::branch_t     br_out;
  logic                 dgn_out;

  assign en[NS] = out_ch.ready;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end
  assign in_ready = en[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // prep: rounded dividend, saturation check, degenerate flag
  logic [CW-1:0] nrm_c;
  assign nrm_c = CW'(in_norm);
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        rem[0][i] <= (CW'(in_mag[i]) << FRAC_BITS) + (nrm_c >> 1);
        sat[0][i] <= ((CW'(in_mag[i]) << FRAC_BITS) + (nrm_c >> 1)) >= (nrm_c << QW);
        quo[0][i] <= '0;
      end
      neg[0] <= in_neg;
      dvs[0] <= nrm_c;
      br[0]  <= in_br;
      dgn[0] <= in_tbad || (in_norm == '0);
    end
  end

  // restoring division, bit QW-s at stage s
  for (genvar s = 1; s <= QW; s++) begin : g_bit
    logic [CW-1:0] shd;
    assign shd = dvs[s-1] << (QW - s);
    always_ff @(posedge clk) begin
      if (en[s]) begin
        for (int i = 0; i < 4; i++) begin
          if (rem[s-1][i] >= shd) begin
            rem[s][i] <= rem[s-1][i] - shd;
            quo[s][i] <= quo[s-1][i] | (QW'(1) << (QW - s));
          end else begin
            rem[s][i] <= rem[s-1][i];
            quo[s][i] <= quo[s-1][i];
          end
        end
        sat[s] <= sat[s-1];
        neg[s] <= neg[s-1];
        dvs[s] <= dvs[s-1];
        br[s]  <= br[s-1];
        dgn[s] <= dgn[s-1];
      end
    end
  end

  // sign, saturation and degenerate masking
  logic signed [OW-1:0] q_next [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [QW-1:0] q;
      q = quo[QW][i];
      if (neg[QW][i]) begin
        if (sat[QW][i] || q > rmq_pkg::NEG_LIM) q = rmq_pkg::NEG_LIM;
        q_next[i] = OW'(-q);
      end else begin
        if (sat[QW][i] || q > rmq_pkg::POS_LIM) q = rmq_pkg::POS_LIM;
        q_next[i] = OW'(q);
      end
      if (dgn[QW]) q_next[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      q_out   <= q_next;
      br_out  <= br[QW];
      dgn_out <= dgn[QW];
    end
  end

  assign out_ch.valid        = vld[NS-1];
  assign out_ch.quat_x       = q_out[0];
  assign out_ch.quat_y       = q_out[1];
  assign out_ch.quat_z       = q_out[2];
  assign out_ch.quat_w       = q_out[3];
  assign out_ch.branch_taken = br_out;
  assign out_ch.degenerate   = dgn_out;

endmodule

[test/rmq_tb_if.sv]
// Testbench-side note: channel interfaces come from the design (rmq_if.sv).
// This file only carries the item record shared by driver and monitor.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
package rmq_tb_pkg;

  typedef struct {
    logic signed [rmq_pkg::ELEM_W-1:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [rmq_pkg::ELEM_W-1:0] q [4];
    rmq_pkg::branch_t                  br;
    logic                              degen;
  } quat_t;
endpackage

[test/rotation_matrix_to_quaternion_tb.sv]
// Testbench for rotation_matrix_to_quaternion: drives matrices, predicts the
// Shepperd quaternion per beat and checks every output beat in order.
// Depends on rmq_pkg, rmq_if and rmq_tb_pkg.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;

  localparam int FRAC = 14;
  localparam int LATENCY = 41;
  localparam int WD_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  rmq_tb_pkg::matrix_t pending_mats [$];
  rmq_tb_pkg::quat_t   expected_quats [$];
  int      src_idle_pct = 0;
  int      snk_stall_pct = 0;
  bit      hold_off = 1'b0;
  bit      in_taken = 1'b0;
  int      mismatches = 0;
  int      idle_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // normalize one component: round half away from zero, saturate to 16 bits
  function automatic logic signed [15:0] norm_comp(longint v, longint unsigned n);
    longint unsigned mg = (v < 0) ? -v : v;
    longint unsigned qt = ((mg << FRAC) + (n >> 1)) / n;
    if (v < 0) begin
      if (qt > 32768) qt = 32768;
      return 16'(-qt);
    end
    if (qt > 32767) qt = 32767;
    return 16'(qt);
  endfunction

  function automatic rmq_tb_pkg::quat_t shepperd_quat(rmq_tb_pkg::matrix_t mt);
    longint a [9];
    longint v [4];
    longint t;
    longint one = 64'sd1 << FRAC;
    longint unsigned n2 = 0;
    longint unsigned n;
    rmq_tb_pkg::quat_t res;
    foreach (a[i]) a[i] = mt.m[i];
    // a: 0=r00 1=r01 2=r02 3=r10 4=r11 5=r12 6=r20 7=r21 8=r22
    if (a[0] + a[4] + a[8] > 0) begin
      res.br = rmq_pkg::BR_TRACE;
      t = one + a[0] + a[4] + a[8];
      v = '{a[7] - a[5], a[2] - a[6], a[3] - a[1], t};
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      res.br = rmq_pkg::BR_X;
      t = one + a[0] - a[4] - a[8];
      v = '{t, a[1] + a[3], a[2] + a[6], a[7] - a[5]};
    end else if (a[4] > a[8]) begin
      res.br = rmq_pkg::BR_Y;
      t = one + a[4] - a[0] - a[8];
      v = '{a[1] + a[3], t, a[5] + a[7], a[2] - a[6]};
    end else begin
      res.br = rmq_pkg::BR_Z;
      t = one + a[8] - a[0] - a[4];
      v = '{a[2] + a[6], a[5] + a[7], t, a[3] - a[1]};
    end
    foreach (v[i]) n2 += longint'(v[i] * v[i]);
    n = int_sqrt(n2);
    res.degen = (t <= 0 || n == 0);
    foreach (res.q[i]) res.q[i] = res.degen ? 16'sd0 : norm_comp(v[i], n);
    return res;
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  // input acceptance, seen at the rising edge
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_quats.push_back(shepperd_quat(pending_mats.pop_front()));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // driver: holds a waiting beat, otherwise presents the next pending matrix
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && !in_taken) begin
        // beat still waiting: keep valid and data
      end else if (pending_mats.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        {in_ch.r00, in_ch.r01, in_ch.r02, in_ch.r10, in_ch.r11, in_ch.r12,
         in_ch.r20, in_ch.r21, in_ch.r22} <=
          {pending_mats[0].m[0], pending_mats[0].m[1], pending_mats[0].m[2],
           pending_mats[0].m[3], pending_mats[0].m[4], pending_mats[0].m[5],
           pending_mats[0].m[6], pending_mats[0].m[7], pending_mats[0].m[8]};
      end else begin
        in_ch.valid <= 1'b0;
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor: compare each output beat with the oldest prediction
  always @(posedge clk) begin
    rmq_tb_pkg::quat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat at %0t", $realtime);
      end else begin
        want = expected_quats.pop_front();
        if (out_ch.quat_x !== want.q[0] || out_ch.quat_y !== want.q[1] ||
            out_ch.quat_z !== want.q[2] || out_ch.quat_w !== want.q[3] ||
            out_ch.branch_taken !== want.br || out_ch.degenerate !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp q=%0d %0d %0d %0d br=%0d dg=%0d got %0d %0d %0d %0d br=%0d dg=%0d",
                     want.q[0], want.q[1], want.q[2], want.q[3], want.br, want.degen,
                     out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w,
                     out_ch.branch_taken, out_ch.degenerate);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // long receiver hold-off, counted here, while the sender keeps offering
  initial begin
    wait (pending_mats.size() > 100 && !rst);
    repeat (20) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic rmq_tb_pkg::matrix_t rand_rotation();
    rmq_tb_pkg::matrix_t mt;
    real ang, c, s, ang2, c2, s2;
    real r [9];
    ang = $urandom_range(0, 62831) / 10000.0;
    ang2 = $urandom_range(0, 62831) / 10000.0;
    c = $cos(ang); s = $sin(ang); c2 = $cos(ang2); s2 = $sin(ang2);
    // Rz(ang) * Rx(ang2)
    r = '{c, -s * c2, s * s2, s, c * c2, -c * s2, 0.0, s2, c2};
    foreach (mt.m[i]) mt.m[i] = 16'($rtoi(r[i] * 16384.0 + ($urandom_range(0, 8) - 4.0)));
    // sign-flip axes to reach every branch
    if ($urandom_range(1)) begin
      mt.m[0] = -mt.m[0]; mt.m[1] = -mt.m[1]; mt.m[3] = -mt.m[3]; mt.m[4] = -mt.m[4];
    end
    if ($urandom_range(1)) begin
      mt.m[4] = -mt.m[4]; mt.m[5] = -mt.m[5]; mt.m[7] = -mt.m[7]; mt.m[8] = -mt.m[8];
    end
    return mt;
  endfunction

  function automatic rmq_tb_pkg::matrix_t diag_mat(int d0, int d1, int d2, int off);
    rmq_tb_pkg::matrix_t mt;
    foreach (mt.m[i]) mt.m[i] = 16'(off);
    mt.m[0] = 16'(d0); mt.m[4] = 16'(d1); mt.m[8] = 16'(d2);
    return mt;
  endfunction

  task automatic drain();
    wait (pending_mats.size() == 0 && expected_quats.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    rmq_tb_pkg::matrix_t mt;
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    {in_ch.r00, in_ch.r01, in_ch.r02, in_ch.r10, in_ch.r11, in_ch.r12,
     in_ch.r20, in_ch.r21, in_ch.r22} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: identity and each branch, extremes, degenerate cases
    pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
    pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));
    pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));
    pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));
    pending_mats.push_back(diag_mat(0, 0, 0, 0));
    pending_mats.push_back(diag_mat(-100, -100, -100, 0));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768, 0));
    pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
    pending_mats.push_back(diag_mat(32767, 32767, 32767, -32768));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768, 32767));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768, -32768));
    pending_mats.push_back(diag_mat(0, 0, -32768, 5));
    pending_mats.push_back(diag_mat(-5000, -5000, -5000, 0));
    pending_mats.push_back(diag_mat(-20000, -20000, 0, 0));
    pending_mats.push_back(diag_mat(-16384, -16384, -16384, 0));
    pending_mats.push_back(diag_mat(1, -1, 0, 0));
    pending_mats.push_back(diag_mat(-16384, -16384, -32768, 32767));
    drain();

    // random phases with different idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 22 : 0;
      snk_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 22 : 0;
      for (int k = 0; k < 135; k++) begin
        if ($urandom_range(99) < 75) begin
          mt = rand_rotation();
        end else begin
          foreach (mt.m[i]) mt.m[i] = 16'($urandom);
        end
        pending_mats.push_back(mt);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
